[hw/rtl/spit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spit_pkg - shared types and constants of the SRTP packet index tracker
// Word layouts, operation and status codes and sequence window constants.
// ----------------------------------------------------------------------------
package spit_pkg;

	// operation codes
	localparam logic [1:0] OP_SEND_RTP  = 2'd0;
	localparam logic [1:0] OP_RX_EST    = 2'd1;
	localparam logic [1:0] OP_RX_COMMIT = 2'd2;
	localparam logic [1:0] OP_SEND_RTCP = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// sequence constants
	localparam logic [15:0]        SEQ_LAST = 16'hFFFF;
	localparam logic signed [15:0] WIN_HI   = 16'sh4000;
	localparam logic signed [15:0] WIN_LO   = -16'sh4000;
	localparam logic [30:0]        IDX_MASK = 31'h7FFF_FFFF;
	localparam logic               E_FLAG   = 1'b1;

	// input word
	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] ssrc;
		logic [15:0] seq;
		logic [31:0] committed_roc;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] roc_out;
		logic [47:0] pkt_index;
		logic [31:0] rtcp_trailer;
	} out_word_t;

	// one table entry
	typedef struct packed {
		logic [31:0] src_id;
		logic [31:0] rollover;
		logic [15:0] highest_seq;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd;
		logic cmp;
		logic exec;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rtcp;
		logic hit;
		logic last;
	} stat_t;

endpackage

[hw/rtl/spit_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spit_ctrl - sequencer of the packet index tracker
// Walks the table one entry at a time (Send-RTCP skips it), then runs the update step.
// ----------------------------------------------------------------------------
module spit_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output spit_pkg::cmd_t  cmd,
	input  spit_pkg::stat_t stat
);
	import spit_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// commands decoded from state
	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.rd   = (state_q == S_READ);
		cmd.cmp  = (state_q == S_CMP);
		cmd.exec = (state_q == S_EXEC) && out_free;
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// result valid: set by the update step, cleared once taken
			if ((state_q == S_EXEC) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_READ;
				end
				S_READ: begin
					// rtcp needs no lookup
					state_q <= stat.rtcp ? S_EXEC : S_CMP;
				end
				S_CMP: begin
					if (stat.hit || stat.last)
						state_q <= S_EXEC;
					else
						state_q <= S_READ;
				end
				S_EXEC: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/spit_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spit_datapath - entry table, scan registers and update logic
// Holds the SSRC table memory with flop valid bits, the RTCP counter and the
// result register.
// ----------------------------------------------------------------------------
module spit_datapath #(
	parameter int TABLE_ENTRIES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spit_pkg::in_word_t  in_data,
	output spit_pkg::out_word_t out_data,
	input  spit_pkg::cmd_t      cmd,
	output spit_pkg::stat_t     stat
);
	import spit_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	entry_t mem [TABLE_ENTRIES];

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         free_idx_q;
	logic                     match_q;
	logic                     free_found_q;
	logic                     rd_vld_q;
	logic [31:0]              rtcp_cnt_q;
	in_word_t                 item_q;
	entry_t                   rd_q;
	out_word_t                out_q;

	logic                     hit;
	entry_t                   ent;
	logic [IDX_W-1:0]         e_idx;
	logic                     have;
	logic signed [15:0]       d;
	logic                     newer;
	logic [31:0]              est;
	logic                     we;
	logic                     set_valid;
	entry_t                   wdata;
	out_word_t                res;

	assign hit       = rd_vld_q && (rd_q.src_id == item_q.ssrc);
	assign stat.hit  = hit;
	assign stat.last = (idx_q == IDX_LAST);
	assign stat.rtcp = (item_q.operation == OP_SEND_RTCP);
	assign out_data  = out_q;

	// selected entry: matched row or a fresh allocation
	always_comb begin
		ent   = match_q ? rd_q
			: entry_t'{src_id: item_q.ssrc, rollover: 32'd0, highest_seq: 16'd0};
		e_idx = match_q ? idx_q : free_idx_q;
		have  = match_q || free_found_q;
		d     = $signed(item_q.seq - ent.highest_seq);
		newer = (item_q.committed_roc > ent.rollover) ||
			((item_q.committed_roc == ent.rollover) && !d[15] && (d != 16'sd0));
	end

	// receive ROC estimate
	always_comb begin
		est = ent.rollover;
		if ((ent.highest_seq != 16'd0) || (ent.rollover != 32'd0)) begin
			if (d < WIN_LO)
				est = ent.rollover + 32'd1;
			else if ((d > WIN_HI) && (ent.rollover != 32'd0))
				est = ent.rollover - 32'd1;
		end
	end

	// result and table update per operation
	always_comb begin
		res       = '0;
		we        = 1'b0;
		set_valid = 1'b0;
		wdata     = ent;
		case (item_q.operation)
			OP_SEND_RTP: begin
				if (!have) begin
					res.status = ST_FULL;
				end else begin
					res.roc_out      = ent.rollover;
					res.pkt_index    = {ent.rollover[31:0], item_q.seq};
					wdata.rollover   = (item_q.seq == SEQ_LAST) ? ent.rollover + 32'd1
						: ent.rollover;
					wdata.highest_seq = item_q.seq;
					we        = 1'b1;
					set_valid = 1'b1;
				end
			end
			OP_RX_EST: begin
				if (!have) begin
					res.status = ST_FULL;
				end else begin
					res.roc_out      = est;
					res.pkt_index    = {est, item_q.seq};
					we        = !match_q;
					set_valid = 1'b1;
				end
			end
			OP_RX_COMMIT: begin
				if (!match_q) begin
					res.status = ST_NOT_FOUND;
				end else begin
					res.roc_out       = item_q.committed_roc;
					res.pkt_index     = {item_q.committed_roc, item_q.seq};
					wdata.rollover    = item_q.committed_roc;
					wdata.highest_seq = item_q.seq;
					we = newer;
				end
			end
			default: begin
				res.rtcp_trailer = {E_FLAG, rtcp_cnt_q[30:0] & IDX_MASK};
			end
		endcase
	end

	// control registers: scan state, valid bits, rtcp counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			idx_q        <= '0;
			free_idx_q   <= '0;
			match_q      <= 1'b0;
			free_found_q <= 1'b0;
			rd_vld_q     <= 1'b0;
			rtcp_cnt_q   <= 32'd0;
		end else begin
			if (cmd.load) begin
				idx_q        <= '0;
				match_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (cmd.rd)
				rd_vld_q <= valid_q[idx_q];
			if (cmd.cmp) begin
				if (hit) begin
					match_q <= 1'b1;
				end else begin
					if (!rd_vld_q && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					if (!stat.last)
						idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.exec) begin
				if (set_valid)
					valid_q[e_idx] <= 1'b1;
				if (item_q.operation == OP_SEND_RTCP)
					rtcp_cnt_q <= rtcp_cnt_q + 32'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= in_data;
		if (cmd.exec)
			out_q <= res;
	end

	// table memory: one read port, one write port
	always_ff @(posedge clk) begin
		if (cmd.rd)
			rd_q <= mem[idx_q];
		if (cmd.exec && we)
			mem[e_idx] <= wdata;
	end

endmodule

[hw/rtl/srtp_packet_index_tracker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtp_packet_index_tracker_top - SRTP rollover counter and index tracker
// Per-SSRC ROC / highest sequence table shared by send and receive, plus the
// SRTCP index counter.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Word
//  in      | in_valid / in_ready   | in_data  (operation, ssrc, seq, committed_roc)
//  out     | out_valid / out_ready | out_data (status, roc_out, pkt_index,
//          |                       |           rtcp_trailer)
//
//  One word at a time. Table walk reads one entry at a time through the
//  table memory's single read port and stops at the first SSRC hit, visiting
//  at most TABLE_ENTRIES entries. Send-RTCP words need no walk. Reset clears
//  valid bits and the counter at once; the table memory needs no clearing
//  pass. A result held by out_ready low stalls the next word only at its
//  update step.
// ----------------------------------------------------------------------------
module srtp_packet_index_tracker_top #(
	parameter int TABLE_ENTRIES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spit_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spit_pkg::out_word_t out_data
);
	import spit_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	spit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	spit_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.out_data (out_data),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
